// ----- src/hrkd_pkg.sv -----
// ----------------------------------------------------------------------------
// hrkd_pkg: shared constants and the keycode translation
// Widths, reset values and the US-layout keycode to ASCII function.
// ----------------------------------------------------------------------------
package hrkd_pkg;

    localparam int          SLOT_COUNT_DEF = 6;
    localparam int          KEY_W          = 8;
    localparam int          ASCII_W        = 7;
    localparam int          OUT_TDATA_W    = 16;
    localparam logic [7:0]  SHIFT_MASK_RST = 8'h22;

    localparam logic [7:0]  KEY_NONE       = 8'h00;
    localparam logic [7:0]  KEY_LETTER_LO  = 8'h04;
    localparam logic [7:0]  KEY_LETTER_HI  = 8'h1d;
    localparam logic [6:0]  CHAR_UPPER_A   = 7'h41;
    localparam logic [6:0]  CHAR_LOWER_A   = 7'h61;

    // Translates one keycode; letters by offset, the rest by a small table.
    function automatic logic [6:0] key_to_ascii(input logic [7:0] code,
                                                input logic       shift);
        logic [6:0] ch;
        logic [7:0] ofs;
        begin
            ofs = code - KEY_LETTER_LO;
            ch  = 7'h00;
            if (code >= KEY_LETTER_LO && code <= KEY_LETTER_HI)
            begin
                ch = (shift ? CHAR_UPPER_A : CHAR_LOWER_A) + ofs[6:0];
            end
            else
            begin
                case (code)
                    8'h1e: ch = shift ? 7'h21 : 7'h31; // ! 1
                    8'h1f: ch = shift ? 7'h40 : 7'h32; // @ 2
                    8'h20: ch = shift ? 7'h23 : 7'h33; // # 3
                    8'h21: ch = shift ? 7'h24 : 7'h34; // $ 4
                    8'h22: ch = shift ? 7'h25 : 7'h35; // % 5
                    8'h23: ch = shift ? 7'h5e : 7'h36; // ^ 6
                    8'h24: ch = shift ? 7'h26 : 7'h37; // & 7
                    8'h25: ch = shift ? 7'h2a : 7'h38; // * 8
                    8'h26: ch = shift ? 7'h28 : 7'h39; // ( 9
                    8'h27: ch = shift ? 7'h29 : 7'h30; // ) 0
                    8'h2c: ch = 7'h20;                 // space
                    8'h2d: ch = shift ? 7'h5f : 7'h2d; // _ -
                    8'h2e: ch = shift ? 7'h2b : 7'h3d; // + =
                    8'h2f: ch = shift ? 7'h7b : 7'h5b; // { [
                    8'h30: ch = shift ? 7'h7d : 7'h5d; // } ]
                    8'h31: ch = shift ? 7'h7c : 7'h5c; // | backslash
                    8'h33: ch = shift ? 7'h3a : 7'h3b; // : ;
                    8'h34: ch = shift ? 7'h22 : 7'h27; // " '
                    8'h35: ch = shift ? 7'h7e : 7'h60; // ~ `
                    8'h36: ch = shift ? 7'h3c : 7'h2c; // < ,
                    8'h37: ch = shift ? 7'h3e : 7'h2e; // > .
                    8'h38: ch = shift ? 7'h3f : 7'h2f; // ? /
                    default: ch = 7'h00;
                endcase
            end
            return ch;
        end
    endfunction

endpackage

// ----- src/hid_report_keypress_decoder.sv -----
// ----------------------------------------------------------------------------
// hid_report_keypress_decoder: boot keyboard report to key press stream
// Turns keyboard reports into one beat per newly pressed key with its ASCII.
// ----------------------------------------------------------------------------
// Usage:
// A report enters on the s_axis channel as one beat: the modifier byte and
// SLOT_COUNT keycode slots. Each slot that is nonzero and missing from the
// previous report leaves on the m_axis channel as one beat, in slot order,
// carrying the keycode, the US-layout character (0 for unmapped keys) and the
// shift flag in tuser; tlast marks the final press of a report. A report with
// no new presses produces no beat but still becomes the previous report.
// The input beat passes through the pending report register and then the
// output register before the first result beat. The block emits one result
// beat per cycle while the receiver is ready; the limit is the single output
// register that presses are drained through. The next report is taken in
// the same cycle as the previous report's last press moves out. If the
// receiver stalls, the pending report and the result beat hold and
// s_axis_tready drops while a report is pending. Reset clears the previous
// report to all zero, sets shift_mask to left and right shift, and empties
// the block. The cfg channel is always ready and should be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module hid_report_keypress_decoder #(
    parameter int SLOT_COUNT = hrkd_pkg::SLOT_COUNT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Report beat, from bit 0: modifier_bits, slot_0 .. slot_(SLOT_COUNT-1).
    input  logic [(SLOT_COUNT+1)*hrkd_pkg::KEY_W-1:0] s_axis_tdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Press beat, from bit 0: pressed_code, ascii_char, one zero pad bit.
    output logic [hrkd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // Press beat user bits: shift_active.
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Shift mask register write.
    input  logic [hrkd_pkg::KEY_W-1:0]            cfg_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready
);
    import hrkd_pkg::*;

    logic [KEY_W-1:0]                 shift_mask_reg;
    logic [KEY_W-1:0]                 shift_mask_next;
    logic [KEY_W-1:0]                 mods;
    logic [SLOT_COUNT-1:0][KEY_W-1:0] slots;
    logic [SLOT_COUNT-1:0]            new_mask;
    logic                             accept;
    logic                             take_ready;
    logic                             shift;
    logic [KEY_W-1:0]                 out_code;
    logic [ASCII_W-1:0]               out_ascii;

    assign mods  = s_axis_tdata[KEY_W-1:0];
    assign slots = s_axis_tdata[(SLOT_COUNT+1)*KEY_W-1:KEY_W];
    assign shift = (mods & shift_mask_reg) != '0;

    assign s_axis_tready = take_ready;
    assign accept        = s_axis_tvalid && take_ready;

    // Configuration: always ready, one register.
    assign cfg_ready       = 1'b1;
    assign shift_mask_next = cfg_valid ? cfg_data : shift_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_mask_reg <= SHIFT_MASK_RST;
        end
        else
        begin
            shift_mask_reg <= shift_mask_next;
        end
    end

    // Compares the report against the previous one and records it.
    hrkd_detect #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_detect (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .slots    (slots),
        .new_mask (new_mask)
    );

    // Drains the new presses one beat per cycle while the output is not stalled.
    hrkd_emit #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_report (accept),
        .slots       (slots),
        .new_mask    (new_mask),
        .shift       (shift),
        .take_ready  (take_ready),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_code    (out_code),
        .out_ascii   (out_ascii),
        .out_shift   (m_axis_tuser),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_ascii, out_code};

endmodule

// ----- src/hrkd_detect.sv -----
// ----------------------------------------------------------------------------
// hrkd_detect: new-press detection
// Holds the previous report's slots and flags each slot of an incoming
// report that is nonzero and absent from the previous report.
// ----------------------------------------------------------------------------
module hrkd_detect #(
    parameter int SLOT_COUNT = hrkd_pkg::SLOT_COUNT_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     accept,
    input  logic [SLOT_COUNT-1:0][hrkd_pkg::KEY_W-1:0] slots,
    output logic [SLOT_COUNT-1:0]                    new_mask
);
    import hrkd_pkg::*;

    logic [SLOT_COUNT-1:0][KEY_W-1:0] prev_reg;
    logic [SLOT_COUNT-1:0][KEY_W-1:0] prev_next;

    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            logic hit;
            hit = 1'b0;
            for (int j = 0; j < SLOT_COUNT; j++)
            begin
                hit = hit | (prev_reg[j] == slots[i]);
            end
            new_mask[i] = (slots[i] != KEY_NONE) && !hit;
        end
    end

    assign prev_next = accept ? slots : prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
        end
    end

endmodule

// ----- src/hrkd_emit.sv -----
// ----------------------------------------------------------------------------
// hrkd_emit: press queue and result register
// Holds one report's pending presses and sends them out lowest slot first,
// one beat per cycle unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
module hrkd_emit #(
    parameter int SLOT_COUNT = hrkd_pkg::SLOT_COUNT_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     load_report,
    input  logic [SLOT_COUNT-1:0][hrkd_pkg::KEY_W-1:0] slots,
    input  logic [SLOT_COUNT-1:0]                    new_mask,
    input  logic                                     shift,
    output logic                                     take_ready,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [hrkd_pkg::KEY_W-1:0]               out_code,
    output logic [hrkd_pkg::ASCII_W-1:0]             out_ascii,
    output logic                                     out_shift,
    output logic                                     out_last
);
    import hrkd_pkg::*;

    logic                             pend_valid_reg;
    logic [SLOT_COUNT-1:0]            pend_mask_reg;
    logic [SLOT_COUNT-1:0][KEY_W-1:0] pend_slots_reg;
    logic                             pend_shift_reg;

    logic                             out_valid_reg;
    logic [KEY_W-1:0]                 code_reg;
    logic [ASCII_W-1:0]               ascii_reg;
    logic                             shift_reg;
    logic                             last_reg;

    logic                             step;
    logic [SLOT_COUNT-1:0]            pick;
    logic [SLOT_COUNT-1:0]            remain;
    logic [KEY_W-1:0]                 pick_code;

    // Lowest pending slot, as a one-hot vector.
    assign pick   = pend_mask_reg & (~pend_mask_reg + {{(SLOT_COUNT-1){1'b0}}, 1'b1});
    assign remain = pend_mask_reg & ~pick;

    always_comb
    begin
        pick_code = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            pick_code = pick_code | (pick[i] ? pend_slots_reg[i] : '0);
        end
    end

    assign step       = pend_valid_reg && (!out_valid_reg || out_ready);
    assign take_ready = !pend_valid_reg || (step && (remain == '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_report)
            begin
                pend_valid_reg <= (new_mask != '0);
            end
            else if (step)
            begin
                pend_valid_reg <= (remain != '0);
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_report)
        begin
            pend_mask_reg  <= new_mask;
            pend_slots_reg <= slots;
            pend_shift_reg <= shift;
        end
        else if (step)
        begin
            pend_mask_reg <= remain;
        end

        if (step)
        begin
            code_reg  <= pick_code;
            ascii_reg <= key_to_ascii(pick_code, pend_shift_reg);
            shift_reg <= pend_shift_reg;
            last_reg  <= (remain == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_code  = code_reg;
    assign out_ascii = ascii_reg;
    assign out_shift = shift_reg;
    assign out_last  = last_reg;

endmodule
